// File: hw/rtl/tdbi_pkg.sv
`timescale 1ns / 1ps

package tdbi_pkg;

    // Field widths of the stream payloads.
    localparam int IDX_W    = 10;
    localparam int SCR_W    = 32;
    localparam int DEP_W    = 8;
    localparam int FACE_W   = 11;
    localparam int TEX_W    = 5;
    localparam int CNT_W    = 12;

    // Vertex store: the address wraps modulo its depth, which is a power of two.
    localparam int VERT_DEPTH = 1024;
    localparam int VERT_AW    = $clog2(VERT_DEPTH);
    localparam int VERT_W     = SCR_W + DEP_W;

    // Depth buckets and face list.
    localparam int BUCKET_COUNT = 766;
    localparam int BUCKET_AW    = $clog2(BUCKET_COUNT);
    localparam int FACE_MAX     = 2048;

    // Stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE     = 1'd1;

    // Item kinds carried in the input tuser.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_SUM,
        ST_HEAD,
        ST_OUT
    } t_state;

    // Source of the vertex store read address.
    typedef enum logic [1:0] {
        VS_IN,
        VS_B,
        VS_C
    } t_vsel;

    typedef struct packed {
        logic in_beat;
        logic in_mode;
        logic in_full;
        logic out_free;
        logic clear_done;
    } t_status;

    typedef struct packed {
        logic  in_ready;
        logic  clear_we;
        t_vsel vsel;
        logic  lat_s0;
        logic  lat_s1;
        logic  sum_en;
        logic  head_en;
        logic  out_try;
    } t_ctrl;

endpackage

// File: hw/rtl/tdbi_ram.sv
`timescale 1ns / 1ps

module tdbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/tdbi_ctrl.sv
`timescale 1ns / 1ps

module tdbi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tdbi_pkg::t_status i_status,
    output tdbi_pkg::t_ctrl   o_ctrl
);

    tdbi_pkg::t_state r_state;
    tdbi_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdbi_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state. A full face list sends a triangle straight to the output.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdbi_pkg::ST_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = tdbi_pkg::ST_IDLE;
                end
            end
            tdbi_pkg::ST_IDLE: begin
                if (i_status.in_beat && i_status.in_mode == tdbi_pkg::MODE_INSERT) begin
                    n_state = i_status.in_full ? tdbi_pkg::ST_OUT : tdbi_pkg::ST_RD1;
                end
            end
            tdbi_pkg::ST_RD1:  n_state = tdbi_pkg::ST_RD2;
            tdbi_pkg::ST_RD2:  n_state = tdbi_pkg::ST_SUM;
            tdbi_pkg::ST_SUM:  n_state = tdbi_pkg::ST_HEAD;
            tdbi_pkg::ST_HEAD: n_state = tdbi_pkg::ST_OUT;
            tdbi_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = tdbi_pkg::ST_IDLE;
                end
            end
            default: n_state = tdbi_pkg::ST_CLEAR;
        endcase
    end

    // Control outputs per state.
    always_comb begin
        o_ctrl = '0;
        o_ctrl.vsel = tdbi_pkg::VS_IN;
        case (r_state)
            tdbi_pkg::ST_CLEAR: o_ctrl.clear_we = 1'b1;
            tdbi_pkg::ST_IDLE:  o_ctrl.in_ready = 1'b1;
            tdbi_pkg::ST_RD1: begin
                o_ctrl.lat_s0 = 1'b1;
                o_ctrl.vsel   = tdbi_pkg::VS_B;
            end
            tdbi_pkg::ST_RD2: begin
                o_ctrl.lat_s1 = 1'b1;
                o_ctrl.vsel   = tdbi_pkg::VS_C;
            end
            tdbi_pkg::ST_SUM:  o_ctrl.sum_en  = 1'b1;
            tdbi_pkg::ST_HEAD: o_ctrl.head_en = 1'b1;
            tdbi_pkg::ST_OUT:  o_ctrl.out_try = 1'b1;
            default:           o_ctrl = '0;
        endcase
    end

endmodule

// File: hw/rtl/triangle_depth_bucket_insert.sv
`timescale 1ns / 1ps

// Depth-bucket triangle insert. Load beats (tuser = 0) write one vertex entry at
// vertex_base + index_a; the block stays idle, ready for the next beat. Insert beats
// (tuser = 1) pass from acceptance through states RD1, RD2, SUM and HEAD until the
// face record is loaded into the output register: the three corner reads go one per
// cycle through the single read port of the vertex memory, followed by the bucket
// head read and its write-back, and the three compare-swaps of the corner sort fall
// in the SUM, HEAD and OUT states. When the face list already holds 2048 faces, an
// insert beat goes straight to OUT and returns a record of zeros with the dropped
// flag set. A stalled output holds the block in OUT until the record can be loaded.
// After reset all 766 bucket heads are cleared, one a cycle, before any beat is taken;
// configuration writes are taken at any time and should only be issued while idle.
module triangle_depth_bucket_insert (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tdbi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tdbi_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input stream.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata from bit 0: index_a[9:0], index_b[19:10], index_c[29:20],
    // screen_word[61:30], vertex_depth[69:62], zero pad[71:70].
    input  logic [tdbi_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // tuser: mode[0].
    input  logic                                 i_s_tuser,
    // Output stream.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // tdata from bit 0: face_number[10:0], top_index[20:11], middle_index[30:21],
    // bottom_index[40:31], next_face[51:41], texture_out[56:52], zero pad[63:57].
    output logic [tdbi_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // tuser: dropped[0].
    output logic                                 o_m_tuser
);

    tdbi_pkg::t_status w_status;
    tdbi_pkg::t_ctrl   w_ctrl;

    // Configuration registers.
    logic [tdbi_pkg::IDX_W-1:0] r_vertex_base;
    logic [tdbi_pkg::TEX_W-1:0] r_texture;

    // Control state.
    logic [tdbi_pkg::BUCKET_AW-1:0] r_clr_addr;
    logic [tdbi_pkg::CNT_W-1:0]     r_count;
    logic                           r_out_valid;

    // Triangle working registers.
    logic [tdbi_pkg::IDX_W-1:0]     r_i0, r_i1, r_i2;
    logic [tdbi_pkg::SCR_W-1:0]     r_s0, r_s1, r_s2;
    logic [tdbi_pkg::DEP_W-1:0]     r_d0, r_d1;
    logic [tdbi_pkg::BUCKET_AW-1:0] r_key;
    logic [tdbi_pkg::FACE_W-1:0]    r_next;
    logic                           r_drop;
    logic [tdbi_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_out_drop;

    // Input fields.
    logic [tdbi_pkg::IDX_W-1:0] w_in_a, w_in_b, w_in_c;
    logic [tdbi_pkg::SCR_W-1:0] w_in_scr;
    logic [tdbi_pkg::DEP_W-1:0] w_in_dep;
    logic                       w_in_beat;
    logic                       w_full;
    logic                       w_out_free;
    logic                       w_out_load;

    // Memory ports.
    logic                            w_vert_we;
    logic [tdbi_pkg::VERT_AW-1:0]    w_vert_waddr;
    logic [tdbi_pkg::VERT_AW-1:0]    w_vert_raddr;
    logic [tdbi_pkg::IDX_W-1:0]      w_vert_ridx;
    logic [tdbi_pkg::VERT_W-1:0]     w_vert_rdata;
    logic [tdbi_pkg::SCR_W-1:0]      w_rd_scr;
    logic [tdbi_pkg::DEP_W-1:0]      w_rd_dep;
    logic                            w_head_we;
    logic [tdbi_pkg::BUCKET_AW-1:0]  w_head_waddr;
    logic [tdbi_pkg::FACE_W-1:0]     w_head_wdata;
    logic [tdbi_pkg::FACE_W-1:0]     w_head_rdata;

    // Depth key and last compare-swap.
    logic [tdbi_pkg::BUCKET_AW-1:0]  w_sum;
    logic [tdbi_pkg::BUCKET_AW-1:0]  w_key;
    logic                            w_swap3;
    logic [tdbi_pkg::IDX_W-1:0]      w_top, w_mid;

    assign w_in_a   = i_s_tdata[9:0];
    assign w_in_b   = i_s_tdata[19:10];
    assign w_in_c   = i_s_tdata[29:20];
    assign w_in_scr = i_s_tdata[61:30];
    assign w_in_dep = i_s_tdata[69:62];

    assign o_s_tready = w_ctrl.in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_in_beat  = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count >= tdbi_pkg::CNT_W'(tdbi_pkg::FACE_MAX));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_out_load = w_ctrl.out_try && w_out_free;

    // A full list skips the memories: the beat goes to the output directly.
    always_comb begin
        w_status.in_beat    = w_in_beat;
        w_status.in_mode    = i_s_tuser;
        w_status.in_full    = w_full;
        w_status.out_free   = w_out_free;
        w_status.clear_done = (r_clr_addr == tdbi_pkg::BUCKET_AW'(tdbi_pkg::BUCKET_COUNT - 1));
    end

    tdbi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_base <= '0;
            r_texture     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tdbi_pkg::CFG_VERTEX_BASE: r_vertex_base <= i_cfg_data[tdbi_pkg::IDX_W-1:0];
                tdbi_pkg::CFG_TEXTURE:     r_texture     <= i_cfg_data[tdbi_pkg::TEX_W-1:0];
                default: ;
            endcase
        end
    end

    // Vertex store: loads write, inserts read their corners one per cycle.
    assign w_vert_we    = w_in_beat && (i_s_tuser == tdbi_pkg::MODE_LOAD);
    assign w_vert_waddr = tdbi_pkg::VERT_AW'(r_vertex_base + w_in_a);

    always_comb begin
        case (w_ctrl.vsel)
            tdbi_pkg::VS_B: w_vert_ridx = r_i1;
            tdbi_pkg::VS_C: w_vert_ridx = r_i2;
            default:        w_vert_ridx = w_in_a;
        endcase
    end
    assign w_vert_raddr = tdbi_pkg::VERT_AW'(r_vertex_base + w_vert_ridx);

    tdbi_ram #(
        .WIDTH (tdbi_pkg::VERT_W),
        .DEPTH (tdbi_pkg::VERT_DEPTH)
    ) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (w_vert_we),
        .i_waddr (w_vert_waddr),
        .i_wdata ({w_in_dep, w_in_scr}),
        .i_raddr (w_vert_raddr),
        .o_rdata (w_vert_rdata)
    );

    assign w_rd_scr = w_vert_rdata[tdbi_pkg::SCR_W-1:0];
    assign w_rd_dep = w_vert_rdata[tdbi_pkg::VERT_W-1:tdbi_pkg::SCR_W];

    // Bucket key from the three corner depths, clamped to the last bucket.
    assign w_sum = tdbi_pkg::BUCKET_AW'(r_d0) + tdbi_pkg::BUCKET_AW'(r_d1)
                 + tdbi_pkg::BUCKET_AW'(w_rd_dep);
    assign w_key = (w_sum > tdbi_pkg::BUCKET_AW'(tdbi_pkg::BUCKET_COUNT - 1))
                 ? tdbi_pkg::BUCKET_AW'(tdbi_pkg::BUCKET_COUNT - 1) : w_sum;

    // Bucket heads: zeroed by the clearing pass, then updated once per face.
    assign w_head_we    = w_ctrl.clear_we || w_ctrl.head_en;
    assign w_head_waddr = w_ctrl.clear_we ? r_clr_addr : r_key;
    assign w_head_wdata = w_ctrl.clear_we ? '0 : r_count[tdbi_pkg::FACE_W-1:0];

    tdbi_ram #(
        .WIDTH (tdbi_pkg::FACE_W),
        .DEPTH (tdbi_pkg::BUCKET_COUNT)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (w_head_waddr),
        .i_wdata (w_head_wdata),
        .i_raddr (w_key),
        .o_rdata (w_head_rdata)
    );

    // Clearing pass address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (w_ctrl.clear_we && !w_status.clear_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Corner capture and the first two compare-swaps.
    always_ff @(posedge i_clk) begin
        if (w_in_beat && i_s_tuser == tdbi_pkg::MODE_INSERT) begin
            r_i0   <= w_in_a;
            r_i1   <= w_in_b;
            r_i2   <= w_in_c;
            r_drop <= w_full;
        end
        if (w_ctrl.lat_s0) begin
            r_s0 <= w_rd_scr;
            r_d0 <= w_rd_dep;
        end
        if (w_ctrl.lat_s1) begin
            r_s1 <= w_rd_scr;
            r_d1 <= w_rd_dep;
        end
        if (w_ctrl.sum_en) begin
            r_key <= w_key;
            r_s2  <= w_rd_scr;
            if (r_s0 > r_s1) begin
                r_s0 <= r_s1;
                r_s1 <= r_s0;
                r_i0 <= r_i1;
                r_i1 <= r_i0;
            end
        end
        if (w_ctrl.head_en) begin
            r_next <= w_head_rdata;
            if (r_s1 > r_s2) begin
                r_s1 <= r_s2;
                r_s2 <= r_s1;
                r_i1 <= r_i2;
                r_i2 <= r_i1;
            end
        end
    end

    // The third compare-swap feeds the output record directly.
    assign w_swap3 = (r_s0 > r_s1);
    assign w_top   = w_swap3 ? r_i1 : r_i0;
    assign w_mid   = w_swap3 ? r_i0 : r_i1;

    // Output register and face counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load && !r_drop) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_drop <= r_drop;
            if (r_drop) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {
                    7'd0,
                    r_texture,
                    r_next,
                    r_i2,
                    w_mid,
                    w_top,
                    r_count[tdbi_pkg::FACE_W-1:0]
                };
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_drop;

    // The face counter never passes the size of the face list.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tdbi_pkg::CNT_W'(tdbi_pkg::FACE_MAX))
        else $error("face counter beyond face list size");

    // The counter only steps by one, and only when a record is loaded.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 12'd1 && $past(w_out_load)))
        else $error("face counter changed without a face");

    // A dropped record carries zeros and only appears once the list is full.
    a_drop_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata == '0 && r_count == tdbi_pkg::CNT_W'(tdbi_pkg::FACE_MAX)))
        else $error("dropped record with data or before list full");

    // No beat is taken while the bucket heads are being cleared.
    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clear_we |-> !o_s_tready)
        else $error("input beat taken during clearing pass");

endmodule
